[rtl/core/blpd_pkg.sv]
package blpd_pkg;

    // Field and state widths
    localparam int NUM_BUTTONS = 3;
    localparam int LPT_W       = 8;
    localparam int TIMER_W     = 16;
    localparam int WORD_W      = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Timer loads are the long press time in tenths times this scale
    localparam logic [6:0] LOAD_SCALE = 7'd100;

    // Configuration register indexes and reset values
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_TIME     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THIRD_BUTTON_ENABLE = 1'd1;
    localparam logic [LPT_W-1:0]       LONG_PRESS_TIME_RESET   = 8'd5;
    localparam logic                   THIRD_ENABLE_RESET      = 1'b1;

    // Request operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic       op;
        logic [2:0] button_levels;
        logic       ptt_level;
        logic       keypad_held;
    } req_t;

    typedef struct packed {
        logic [2:0] pressed_bits;
        logic [2:0] short_up_bits;
        logic [2:0] long_down_bits;
        logic [2:0] very_long_bits;
        logic       ptt_active;
        logic       changed;
    } rsp_t;

    // Per-button press flags
    typedef struct packed {
        logic held_extra;
        logic held_long;
        logic pressed;
    } flags_t;

    // How a sample treats a button channel
    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_HOLD,
        MODE_RESET
    } mode_t;

    // Control from the top level to one channel
    typedef struct packed {
        logic  fire;
        logic  tick;
        mode_t mode;
        logic  enable;
        logic  level;
    } chan_ctrl_t;

    // Events one channel reports for a sample
    typedef struct packed {
        logic short_up;
        logic long_down;
        logic very_long;
    } chan_evt_t;

endpackage

[rtl/core/blpd_channel.sv]
module blpd_channel
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  blpd_pkg::chan_ctrl_t               ctrl,
    input  logic [blpd_pkg::TIMER_W-1:0]       long_load,
    input  logic [blpd_pkg::TIMER_W-1:0]       extra_load,
    output blpd_pkg::chan_evt_t                report
);

    blpd_pkg::flags_t                   flags_reg;
    blpd_pkg::flags_t                   flags_next;
    blpd_pkg::flags_t                   flags_fresh;
    logic [blpd_pkg::TIMER_W-1:0]       timer_reg;
    logic [blpd_pkg::TIMER_W-1:0]       timer_next;
    logic [blpd_pkg::TIMER_W-1:0]       timer_fresh;

    // A fresh press loads the timer and clears the long flags
    always_comb
    begin
        flags_fresh = flags_reg;
        timer_fresh = timer_reg;
        if (ctrl.enable && ctrl.level && !flags_reg.pressed)
        begin
            flags_fresh = '{held_extra: 1'b0, held_long: 1'b0, pressed: 1'b1};
            timer_fresh = long_load;
        end
    end

    // Press classification for a normal sample
    always_comb
    begin
        report = '0;
        if (ctrl.mode == blpd_pkg::MODE_NORMAL && ctrl.enable && flags_fresh.pressed)
        begin
            if (ctrl.level)
            begin
                if (flags_fresh.held_long && !flags_fresh.held_extra)
                begin
                    if (timer_fresh == '0)
                        report.very_long = 1'b1;
                    else
                        report.long_down = 1'b1;
                end
                else if (flags_fresh.held_long)
                    report.very_long = 1'b1;
                else if (timer_fresh == '0)
                    report.long_down = 1'b1;
            end
            else if (!flags_fresh.held_long && timer_fresh != '0)
                report.short_up = 1'b1;
        end
    end

    // Next state of flags and timer
    always_comb
    begin
        flags_next = flags_reg;
        timer_next = timer_reg;
        if (ctrl.fire)
        begin
            if (ctrl.tick)
            begin
                if (timer_reg != '0)
                    timer_next = timer_reg - blpd_pkg::TIMER_W'(1);
            end
            else
            begin
                case (ctrl.mode)
                    blpd_pkg::MODE_RESET:
                    begin
                        if (ctrl.enable)
                        begin
                            flags_next = '{held_extra: 1'b0, held_long: 1'b0,
                                           pressed: ctrl.level};
                            timer_next = ctrl.level ? long_load : '0;
                        end
                    end
                    blpd_pkg::MODE_HOLD:
                    begin
                        flags_next = flags_fresh;
                        timer_next = timer_fresh;
                    end
                    blpd_pkg::MODE_NORMAL:
                    begin
                        flags_next = flags_fresh;
                        timer_next = timer_fresh;
                        if (ctrl.enable && flags_fresh.pressed)
                        begin
                            if (ctrl.level)
                            begin
                                if (flags_fresh.held_long && !flags_fresh.held_extra)
                                begin
                                    if (timer_fresh == '0)
                                        flags_next.held_extra = 1'b1;
                                end
                                else if (!flags_fresh.held_long && timer_fresh == '0)
                                begin
                                    flags_next.held_long = 1'b1;
                                    timer_next = extra_load;
                                end
                            end
                            else if (!flags_fresh.held_long)
                            begin
                                if (timer_fresh != '0)
                                begin
                                    flags_next = '0;
                                    timer_next = '0;
                                end
                            end
                            else
                                flags_next = '0;
                        end
                    end
                    default:
                    begin
                        flags_next = flags_reg;
                        timer_next = timer_reg;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            timer_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            timer_reg <= timer_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Extra long is only ever reached through long
    a_extra_needs_long: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.held_extra |-> flags_reg.held_long)
        else $error("extra-long flag without long flag");

    // Long flags only on a pressed button
    a_long_needs_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.held_long |-> flags_reg.pressed)
        else $error("long flag without pressed flag");

    // A tick never touches the flags
    a_tick_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fire && ctrl.tick) |=> $stable(flags_reg))
        else $error("flags changed on a tick");
`endif

endmodule

[rtl/core/button_long_press_detector_unit.sv]
// Side-button short / long / extra-long press detector.
// Request channel (sample_valid / sample_ready / sample): each request is either
// a sample of the button levels, PTT and keypad-held flag, or one timer tick.
// Result channel (result_valid / result_ready / result): one result per sample,
// none per tick. Results come out in request order.
// Pipeline: a sample passes the request register, then the result register, and its
// result is valid once it sits in the result register.
// Throughput: one request per cycle unless a waiting result stalls a sample; the three
// button channels update in parallel from the request register, so nothing iterates.
// Stall: when the receiver holds result_ready low the result register holds;
// one more sample waits in the request register and then sample_ready drops.
// Ticks keep flowing through the request register while a result waits.
// Configuration (cfg_write / cfg_index / cfg_data) is written with no wait:
// index 0 is the long press time in tenths, index 1 enables the third button.
// Reset clears all timers, flags and the previous word, empties both
// registers, and sets the long press time to 5 and the third button enabled.
module button_long_press_detector_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  blpd_pkg::req_t                      sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output blpd_pkg::rsp_t                      result,
    input  logic                                cfg_write,
    input  logic [blpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [blpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [blpd_pkg::LPT_W-1:0]     lpt_reg;
    logic                           third_en_reg;

    blpd_pkg::req_t                 req_reg;
    logic                           req_valid_reg;
    logic                           req_valid_next;
    logic                           advance;

    blpd_pkg::rsp_t                 rsp_reg;
    blpd_pkg::rsp_t                 rsp_next;
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;

    logic [blpd_pkg::WORD_W-1:0]    prev_word_reg;
    logic [blpd_pkg::WORD_W-1:0]    prev_word_next;
    logic                           waiting_reg;
    logic                           waiting_next;

    logic [14:0]                    long_prod;
    logic [9:0]                     lpt_x3;
    logic [8:0]                     lpt_x1p5;
    logic [blpd_pkg::TIMER_W-1:0]   long_load;
    logic [blpd_pkg::TIMER_W-1:0]   extra_load;

    logic [2:0]                     levels;
    logic [3:0]                     short_word;
    logic [blpd_pkg::WORD_W-1:0]    full_word;
    logic                           is_sample;
    blpd_pkg::mode_t                mode;

    blpd_pkg::chan_ctrl_t           chan_ctrl [blpd_pkg::NUM_BUTTONS];
    blpd_pkg::chan_evt_t            chan_evt  [blpd_pkg::NUM_BUTTONS];
    logic [2:0]                     sh_bits;
    logic [2:0]                     lg_bits;
    logic [2:0]                     xl_bits;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpt_reg      <= blpd_pkg::LONG_PRESS_TIME_RESET;
            third_en_reg <= blpd_pkg::THIRD_ENABLE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                blpd_pkg::REG_LONG_PRESS_TIME:     lpt_reg      <= cfg_data;
                blpd_pkg::REG_THIRD_BUTTON_ENABLE: third_en_reg <= cfg_data[0];
                default:                           lpt_reg      <= lpt_reg;
            endcase
        end
    end

    // Timer load values: time*100 and ((time*3)>>1)*100
    assign long_prod  = {7'd0, lpt_reg} * {8'd0, blpd_pkg::LOAD_SCALE};
    assign long_load  = {1'b0, long_prod};
    assign lpt_x3     = {2'b00, lpt_reg} + {1'b0, lpt_reg, 1'b0};
    assign lpt_x1p5   = lpt_x3[9:1];
    assign extra_load = {7'd0, lpt_x1p5} * {9'd0, blpd_pkg::LOAD_SCALE};

    // Request register handshake; a tick never needs the result register
    assign is_sample    = (req_reg.op == blpd_pkg::OP_SAMPLE);
    assign advance      = req_valid_reg && (!is_sample || !rsp_valid_reg || result_ready);
    assign sample_ready = !req_valid_reg || advance;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (sample_valid && sample_ready)
            req_valid_next = 1'b1;
        else if (advance)
            req_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else
            req_valid_reg <= req_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            req_reg <= sample;
    end

    // Sample decode: levels, short word and channel mode
    assign levels     = req_reg.button_levels & {third_en_reg, 2'b11};
    assign short_word = {req_reg.ptt_level, levels};

    always_comb
    begin
        mode = blpd_pkg::MODE_NORMAL;
        if (short_word != '0 || waiting_reg)
        begin
            if (req_reg.keypad_held)
                mode = blpd_pkg::MODE_RESET;
            else if (waiting_reg)
            begin
                if ({9'd0, short_word} != prev_word_reg)
                    mode = blpd_pkg::MODE_RESET;
                else
                    mode = blpd_pkg::MODE_HOLD;
            end
        end
    end

    // Button channels
    for (genvar b = 0; b < blpd_pkg::NUM_BUTTONS; b++)
    begin : g_chan
        assign chan_ctrl[b].fire   = advance;
        assign chan_ctrl[b].tick   = !is_sample;
        assign chan_ctrl[b].mode   = mode;
        assign chan_ctrl[b].enable = (b < blpd_pkg::NUM_BUTTONS - 1) ? 1'b1 : third_en_reg;
        assign chan_ctrl[b].level  = levels[b];

        blpd_channel u_chan
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (chan_ctrl[b]),
            .long_load  (long_load),
            .extra_load (extra_load),
            .report     (chan_evt[b])
        );

        assign sh_bits[b] = chan_evt[b].short_up;
        assign lg_bits[b] = chan_evt[b].long_down;
        assign xl_bits[b] = chan_evt[b].very_long;
    end

    assign full_word = {xl_bits, lg_bits, sh_bits, short_word};

    // Result, previous word and wait flag for a sample
    always_comb
    begin
        rsp_next                 = '0;
        rsp_next.pressed_bits    = levels;
        rsp_next.ptt_active      = req_reg.ptt_level;
        prev_word_next           = prev_word_reg;
        waiting_next             = waiting_reg;
        case (mode)
            blpd_pkg::MODE_RESET:
            begin
                prev_word_next   = {9'd0, short_word};
                waiting_next     = req_reg.keypad_held;
                rsp_next.changed = !req_reg.keypad_held;
            end
            blpd_pkg::MODE_HOLD:
            begin
                rsp_next.changed = 1'b0;
            end
            blpd_pkg::MODE_NORMAL:
            begin
                rsp_next.short_up_bits  = sh_bits;
                rsp_next.long_down_bits = lg_bits;
                rsp_next.very_long_bits = xl_bits;
                rsp_next.changed        = (full_word != prev_word_reg);
                prev_word_next          = full_word;
            end
            default:
            begin
                rsp_next.changed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_word_reg <= '0;
            waiting_reg   <= 1'b0;
        end
        else if (advance && is_sample)
        begin
            prev_word_reg <= prev_word_next;
            waiting_reg   <= waiting_next;
        end
    end

    // Result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (advance && is_sample)
            rsp_valid_next = 1'b1;
        else if (result_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_sample)
            rsp_reg <= rsp_next;
    end

    assign result_valid = rsp_valid_reg;
    assign result       = rsp_reg;

`ifndef NO_ASSERTIONS
    // A button is never both long and extra long in one result
    a_long_extra_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((rsp_reg.long_down_bits & rsp_reg.very_long_bits) == 3'b000))
        else $error("long and extra-long on the same button");

    // Long and extra long only on a button that is down
    a_long_on_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (((rsp_reg.long_down_bits | rsp_reg.very_long_bits)
                            & ~rsp_reg.pressed_bits) == 3'b000))
        else $error("long report on a released button");

    // Short release only on a button that is up
    a_short_on_released: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((rsp_reg.short_up_bits & rsp_reg.pressed_bits) == 3'b000))
        else $error("short release on a pressed button");

    // A tick leaves the result register alone
    a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_sample && !rsp_valid_reg) |=> !rsp_valid_reg)
        else $error("tick produced a result");
`endif

endmodule

[tb/press_event_checker.sv]
module press_event_checker
    import blpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    input  logic                   sample_ready,
    input  req_t                   sample,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  rsp_t                   result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     pending,
    output int                     checked,
    output int                     short_seen,
    output int                     long_seen,
    output int                     extra_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the detector state and its two registers
    logic [LPT_W-1:0]   hold_tenths;
    logic               third_on;
    logic [TIMER_W-1:0] press_tmr [NUM_BUTTONS];
    flags_t             press_flg [NUM_BUTTONS];
    logic [WORD_W-1:0]  last_word;
    logic               await_change;

    // Results still owed by the block, oldest first
    rsp_t               owed_results [$];

    function automatic logic [TIMER_W-1:0] long_reload(input logic [LPT_W-1:0] tenths);
        return TIMER_W'(int'(tenths) * 100);
    endfunction

    function automatic logic [TIMER_W-1:0] extra_reload(input logic [LPT_W-1:0] tenths);
        return TIMER_W'(((int'(tenths) * 3) >> 1) * 100);
    endfunction

    // Restart one button from its current level
    task automatic restart_channel(input int b, input logic lvl);
        press_flg[b] = '0;
        press_flg[b].pressed = lvl;
        press_tmr[b] = lvl ? long_reload(hold_tenths) : '0;
    endtask

    // Work out what one accepted request does to the state and what it reports
    task automatic predict_request(input req_t r);
        int                 b;
        int                 nb;
        logic [2:0]         lv;
        logic [2:0]         sh;
        logic [2:0]         lg;
        logic [2:0]         xl;
        logic [WORD_W-1:0]  word;
        flags_t             f;
        logic [TIMER_W-1:0] t;
        rsp_t               want;
        logic               settled;

        // a tick only counts the running timers down
        if (r.op == OP_TICK)
        begin
            for (b = 0; b < NUM_BUTTONS; b++)
            begin
                if (press_tmr[b] != '0)
                    press_tmr[b] = press_tmr[b] - 1'b1;
            end
            return;
        end

        nb = third_on ? 3 : 2;
        lv = r.button_levels;
        if (!third_on)
            lv[2] = 1'b0;
        sh = '0;
        lg = '0;
        xl = '0;
        settled = 1'b0;
        want = '0;
        want.pressed_bits = lv;
        want.ptt_active = r.ptt_level;

        // fresh presses load their timers
        for (b = 0; b < nb; b++)
        begin
            if (lv[b] && !press_flg[b].pressed)
                restart_channel(b, 1'b1);
        end

        // keypad modifier and wait-for-new-state handling
        word = {9'd0, r.ptt_level, lv};
        if (word != '0 || await_change)
        begin
            if (r.keypad_held)
            begin
                await_change = 1'b1;
                for (b = 0; b < nb; b++)
                    restart_channel(b, lv[b]);
                last_word = word;
                settled = 1'b1;
            end
            else if (await_change)
            begin
                if (word != last_word)
                begin
                    await_change = 1'b0;
                    for (b = 0; b < nb; b++)
                        restart_channel(b, lv[b]);
                    last_word = word;
                    want.changed = 1'b1;
                end
                settled = 1'b1;
            end
        end

        // per button press / long / extra long tracking
        if (!settled)
        begin
            for (b = 0; b < nb; b++)
            begin
                f = press_flg[b];
                t = press_tmr[b];
                if (f.pressed)
                begin
                    if (lv[b])
                    begin
                        if (f.held_long && !f.held_extra)
                        begin
                            if (t == '0)
                            begin
                                press_flg[b].held_extra = 1'b1;
                                xl[b] = 1'b1;
                            end
                            else
                                lg[b] = 1'b1;
                        end
                        else if (f.held_long)
                            xl[b] = 1'b1;
                        else if (t == '0)
                        begin
                            press_flg[b].held_long = 1'b1;
                            lg[b] = 1'b1;
                            press_tmr[b] = extra_reload(hold_tenths);
                        end
                    end
                    else if (!f.held_long)
                    begin
                        // released at expiry leaves the press pending
                        if (t != '0)
                        begin
                            press_flg[b] = '0;
                            press_tmr[b] = '0;
                            sh[b] = 1'b1;
                        end
                    end
                    else
                        press_flg[b] = '0;
                end
            end
            word = {xl, lg, sh, r.ptt_level, lv};
            want.short_up_bits = sh;
            want.long_down_bits = lg;
            want.very_long_bits = xl;
            want.changed = (word != last_word);
            last_word = word;
        end
        owed_results.push_back(want);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result(input rsp_t got);
        rsp_t want;

        if (owed_results.size() == 0)
        begin
            mismatches++;
            $display("%0t: result %h arrived, expected none", $time, got);
            return;
        end
        want = owed_results.pop_front();
        checked++;
        if (want.short_up_bits != '0)
            short_seen++;
        if (want.long_down_bits != '0)
            long_seen++;
        if (want.very_long_bits != '0)
            extra_seen++;
        compare_field("pressed_bits", want.pressed_bits, got.pressed_bits);
        compare_field("short_up_bits", want.short_up_bits, got.short_up_bits);
        compare_field("long_down_bits", want.long_down_bits, got.long_down_bits);
        compare_field("very_long_bits", want.very_long_bits, got.very_long_bits);
        compare_field("ptt_active", want.ptt_active, got.ptt_active);
        compare_field("changed", want.changed, got.changed);
    endtask

    // Watch the ports: register writes, results, then new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_tenths = LONG_PRESS_TIME_RESET;
            third_on = THIRD_ENABLE_RESET;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                press_tmr[b] = '0;
                press_flg[b] = '0;
            end
            last_word = '0;
            await_change = 1'b0;
            owed_results.delete();
            mismatches = 0;
            pending = 0;
            checked = 0;
            short_seen = 0;
            long_seen = 0;
            extra_seen = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_LONG_PRESS_TIME)
                    hold_tenths = cfg_data;
                else if (cfg_index == REG_THIRD_BUTTON_ENABLE)
                    third_on = cfg_data[0];
            end
            if (result_valid && result_ready)
                check_result(result);
            if (sample_valid && sample_ready)
                predict_request(sample);
            pending = owed_results.size();
        end
    end

endmodule

[tb/tb.sv]
module tb;
    import blpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 6;
    localparam int STALL_LIMIT     = 3000;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   sample_valid = 1'b0;
    logic                   sample_ready;
    req_t                   sample = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    rsp_t                   result;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatches;
    int pending;
    int checked;
    int short_seen;
    int long_seen;
    int extra_seen;

    // Stimulus knobs shared with the receiver process
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_off_req = 1'b0;

    int sent = 0;
    int ticks_sent = 0;
    int settings_used = 1;

    button_long_press_detector_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    press_event_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .short_seen   (short_seen),
        .long_seen    (long_seen),
        .extra_seen   (extra_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic req_t sample_of(input logic [2:0] levels, input logic ptt,
                                       input logic keypad);
        req_t r;
        r.op = OP_SAMPLE;
        r.button_levels = levels;
        r.ptt_level = ptt;
        r.keypad_held = keypad;
        return r;
    endfunction

    // Tick with junk in the unused fields
    function automatic req_t tick_req();
        req_t r;
        r = req_t'(6'($urandom));
        r.op = OP_TICK;
        return r;
    endfunction

    // Offer one request, with an occasional idle burst before it
    task automatic send_req(input req_t r);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= r;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        sent++;
        if (r.op == OP_TICK)
            ticks_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_req(tick_req());
    endtask

    // Stop offering and let every owed result come back
    task automatic drain();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [LPT_W-1:0] tenths, input logic third);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= REG_LONG_PRESS_TIME;
        cfg_data <= tenths;
        @(posedge clk);
        cfg_index <= REG_THIRD_BUTTON_ENABLE;
        cfg_data <= CFG_DATA_W'(third);
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Mostly press / hold / release sessions, plus keypad use and raw noise
    task automatic run_presses(input int n);
        int         stop_at;
        logic [2:0] held;
        logic       ptt;

        stop_at = sent + n;
        while (sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    held = 3'($urandom_range(1, 7));
                    ptt = 1'($urandom_range(0, 1));
                    send_req(sample_of(held, ptt, 1'b0));
                    repeat ($urandom_range(1, 5))
                    begin
                        send_ticks($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                        : $urandom_range(20, 60));
                        if ($urandom_range(0, 7) == 0)
                            ptt = ~ptt;
                        send_req(sample_of(held, ptt, 1'b0));
                    end
                    // partial, full or no release
                    send_req(sample_of(held & 3'($urandom), ptt, 1'b0));
                    if ($urandom_range(0, 1) == 1)
                        send_req(sample_of(3'd0, 1'b0, 1'b0));
                end
                6, 7:
                begin
                    send_req(sample_of(3'($urandom), 1'($urandom), 1'b1));
                    repeat ($urandom_range(1, 3))
                        send_req(sample_of(3'($urandom), 1'($urandom),
                                           1'($urandom_range(0, 3) == 0)));
                end
                default:
                    send_req(req_t'(6'($urandom)));
            endcase
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin : rx_side
        int stall;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                result_ready <= 1'b1;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                result_ready <= 1'b0;
                stall = $urandom_range(1, 18);
                repeat (stall) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Ends the run when neither channel moves for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: plain presses, short releases, keypad modifier
        tx_idle_pct = 5;
        rx_idle_pct = 5;
        send_req(sample_of(3'd0, 1'b0, 1'b0));
        send_req(sample_of(3'd7, 1'b1, 1'b0));
        send_req('{OP_TICK, 3'b111, 1'b1, 1'b1});
        send_req(sample_of(3'd7, 1'b1, 1'b0));
        send_req(sample_of(3'd0, 1'b0, 1'b0));
        send_req(sample_of(3'd5, 1'b0, 1'b1));
        send_req(sample_of(3'd5, 1'b0, 1'b0));
        send_req(sample_of(3'd2, 1'b0, 1'b0));
        send_req(sample_of(3'd0, 1'b0, 1'b0));
        send_req(sample_of(3'd0, 1'b0, 1'b1));

        // zero long time: long and extra long on back-to-back samples
        apply_settings(8'd0, 1'b1);
        send_req(sample_of(3'd1, 1'b0, 1'b0));
        send_req(sample_of(3'd1, 1'b0, 1'b0));
        send_req(sample_of(3'd1, 1'b0, 1'b0));
        send_req(sample_of(3'd0, 1'b0, 1'b0));
        // release right at expiry, then a new press reports long at once
        send_req(sample_of(3'd1, 1'b0, 1'b1));
        send_req(sample_of(3'd1, 1'b1, 1'b0));
        send_req(sample_of(3'd0, 1'b1, 1'b0));
        send_req(sample_of(3'd1, 1'b1, 1'b0));
        send_req(sample_of(3'd0, 1'b0, 1'b0));

        // third button disabled reads as released
        apply_settings(8'd0, 1'b0);
        send_req(sample_of(3'd4, 1'b1, 1'b0));
        send_req(sample_of(3'd7, 1'b0, 1'b0));
        send_req(sample_of(3'd0, 1'b0, 1'b0));

        // random sessions over several settings
        apply_settings(8'd1, 1'b1);
        tx_idle_pct = 6;
        rx_idle_pct = 6;
        run_presses(400);

        apply_settings(8'd0, 1'b0);
        tx_idle_pct = 4;
        rx_idle_pct = 4;
        hold_off_req = 1'b1;
        run_presses(150);

        apply_settings(8'd255, 1'b1);
        tx_idle_pct = 8;
        rx_idle_pct = 0;
        run_presses(100);

        apply_settings(8'd2, 1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 8;
        run_presses(250);

        // closing stretch at full rate
        apply_settings(8'd1, 1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_presses(200);

        drain();
        $display("%0d requests sent (%0d ticks), %0d results checked, %0d register settings",
                 sent, ticks_sent, checked, settings_used);
        $display("results with short releases %0d, long holds %0d, extra long holds %0d",
                 short_seen, long_seen, extra_seen);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
